[rtl/rspe_pkg.sv]
// ----------------------------------------------------------------------------
// Remote switch pulse encoder package
// Shared types, register indexes and reset values for the pulse encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

    // Width of the register index and write data on the configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;
    localparam int FRAME_W    = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FRAMES = 2'd3;

    // Register values after reset
    localparam logic [TICK_W-1:0]  RST_START_TICKS   = 16'd500;
    localparam logic [TICK_W-1:0]  RST_SHORT_TICKS   = 16'd100;
    localparam logic [TICK_W-1:0]  RST_LONG_TICKS    = 16'd300;
    localparam logic [FRAME_W-1:0] RST_REPEAT_FRAMES = 8'd181;

    // One result item
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic accepted;
    } t_result;

    // A zero duration acts as one tick
    function automatic logic [TICK_W-1:0] min_one_ticks(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // A zero repeat count acts as one frame
    function automatic logic [FRAME_W-1:0] min_one_frames(input logic [FRAME_W-1:0] v);
        return (v == '0) ? FRAME_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

[rtl/rspe_out_skid.sv]
// ----------------------------------------------------------------------------
// Pulse encoder result buffer
// Output register plus one skid entry, so a new item is taken while a
// finished result still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_out_skid (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  rspe_pkg::t_result  i_data,
    output logic               o_space,
    output logic               o_valid,
    input  wire                i_ready,
    output rspe_pkg::t_result  o_data
);
    import rspe_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // Hold, refill or drain the two entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main       <= i_data;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // The skid entry is only used behind a waiting main entry
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry valid without main entry");

    // No push lands while both entries are full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("item pushed into full result buffer");

    // A result pushed into an empty buffer shows up next cycle
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_main_valid) |=> r_main_valid)
        else $error("pushed result not presented");

endmodule

`default_nettype wire

[rtl/remote_switch_pulse_encoder_core.sv]
// ----------------------------------------------------------------------------
// Remote switch pulse encoder core
// On-off keyed, pulse-width coded frame generator for remote power switches.
// ----------------------------------------------------------------------------
// Each item is handled at its accept edge: the encoder state is updated there
// and the result goes into an output register, so one item per cycle is
// sustained while the output side takes results. A send item (func 1) latches
// the remote ID and key code and starts a transmission unless one is running;
// each tick item (func 0) returns the pin level for that tick. A frame is a
// high start segment, then ID_BITS + KEY_BITS data bits MSB first; a zero bit
// is two short segments, a one bit one long segment, data segments alternate
// starting low. Frames repeat repeat_frames times, then the pin idles low.
// Write the timing registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_switch_pulse_encoder_core #(
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input items
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_func,
    input  wire  [ID_BITS-1:0]                  i_remote_id,
    input  wire  [KEY_BITS-1:0]                 i_key_code,
    // Result items
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_pin_level,
    output logic                                o_busy_res,
    output logic                                o_accepted,
    // Configuration writes
    input  wire                                 i_cfg_we,
    input  wire  [rspe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [rspe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rspe_pkg::*;

    localparam int TOTAL_BITS = ID_BITS + KEY_BITS;
    localparam int POS_W      = $clog2(TOTAL_BITS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TOTAL_BITS - 1);

    // Configuration registers
    logic [TICK_W-1:0]  r_start_ticks;
    logic [TICK_W-1:0]  r_short_ticks;
    logic [TICK_W-1:0]  r_long_ticks;
    logic [FRAME_W-1:0] r_repeat_frames;

    // Encoder state
    logic                  r_active,     n_active;
    logic [TOTAL_BITS-1:0] r_frame_bits, n_frame_bits;
    logic [POS_W-1:0]      r_bit_pos,    n_bit_pos;
    logic                  r_in_start,   n_in_start;
    logic                  r_half_step,  n_half_step;
    logic                  r_phase_high, n_phase_high;
    logic [TICK_W-1:0]     r_seg_timer,  n_seg_timer;
    logic [FRAME_W-1:0]    r_frames_left, n_frames_left;

    logic              in_accept;
    logic              cur_bit;
    logic              cur_level;
    logic [TICK_W-1:0] cur_length;
    logic [TICK_W:0]   timer_inc;
    logic [FRAME_W-1:0] frames_dec;
    t_result           res;
    t_result           out_res;
    logic              buf_space;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = buf_space;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_ticks   <= RST_START_TICKS;
            r_short_ticks   <= RST_SHORT_TICKS;
            r_long_ticks    <= RST_LONG_TICKS;
            r_repeat_frames <= RST_REPEAT_FRAMES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_TICKS:   r_start_ticks   <= i_cfg_data;
                CFG_SHORT_TICKS:   r_short_ticks   <= i_cfg_data;
                CFG_LONG_TICKS:    r_long_ticks    <= i_cfg_data;
                CFG_REPEAT_FRAMES: r_repeat_frames <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Current segment level and length
    assign cur_bit    = r_frame_bits[r_bit_pos];
    assign cur_level  = r_active && (r_in_start || !r_phase_high);
    assign cur_length = r_in_start ? min_one_ticks(r_start_ticks) :
                        (cur_bit ? min_one_ticks(r_long_ticks)
                                 : min_one_ticks(r_short_ticks));
    assign timer_inc  = {1'b0, r_seg_timer} + (TICK_W+1)'(1);
    assign frames_dec = r_frames_left - FRAME_W'(1);

    // Advance the encoder for one item
    always_comb begin
        n_active      = r_active;
        n_frame_bits  = r_frame_bits;
        n_bit_pos     = r_bit_pos;
        n_in_start    = r_in_start;
        n_half_step   = r_half_step;
        n_phase_high  = r_phase_high;
        n_seg_timer   = r_seg_timer;
        n_frames_left = r_frames_left;
        res.pin_level = cur_level;
        res.accepted  = 1'b0;

        if (i_func) begin
            // Start a transmission unless one is running
            if (!r_active) begin
                n_frame_bits  = {i_remote_id, i_key_code};
                n_active      = 1'b1;
                n_in_start    = 1'b1;
                n_half_step   = 1'b0;
                n_phase_high  = 1'b1;
                n_bit_pos     = '0;
                n_seg_timer   = '0;
                n_frames_left = min_one_frames(r_repeat_frames);
                res.accepted  = 1'b1;
                res.pin_level = 1'b1;
            end
        end else if (r_active) begin
            n_seg_timer = timer_inc[TICK_W-1:0];
            if (timer_inc >= {1'b0, cur_length}) begin
                // Segment done: move to the next one
                n_seg_timer = '0;
                if (r_in_start) begin
                    n_in_start   = 1'b0;
                    n_phase_high = 1'b1;
                    n_half_step  = 1'b0;
                    n_bit_pos    = LAST_POS;
                end else begin
                    n_phase_high = !r_phase_high;
                    if (!cur_bit && !r_half_step) begin
                        n_half_step = 1'b1;
                    end else begin
                        n_half_step = 1'b0;
                        if (r_bit_pos == '0) begin
                            n_frames_left = frames_dec;
                            if (frames_dec == '0) begin
                                n_active = 1'b0;
                            end else begin
                                n_in_start = 1'b1;
                            end
                        end else begin
                            n_bit_pos = r_bit_pos - POS_W'(1);
                        end
                    end
                end
            end
        end
        res.busy_res = n_active;
    end

    // Hold encoder state between accepted items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_frame_bits  <= '0;
            r_bit_pos     <= '0;
            r_in_start    <= 1'b0;
            r_half_step   <= 1'b0;
            r_phase_high  <= 1'b1;
            r_seg_timer   <= '0;
            r_frames_left <= '0;
        end else if (in_accept) begin
            r_active      <= n_active;
            r_frame_bits  <= n_frame_bits;
            r_bit_pos     <= n_bit_pos;
            r_in_start    <= n_in_start;
            r_half_step   <= n_half_step;
            r_phase_high  <= n_phase_high;
            r_seg_timer   <= n_seg_timer;
            r_frames_left <= n_frames_left;
        end
    end

    // Result register with skid entry
    rspe_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (res),
        .o_space (buf_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_pin_level = out_res.pin_level;
    assign o_busy_res  = out_res.busy_res;
    assign o_accepted  = out_res.accepted;

    // A running transmission always has frames left, an idle one none
    a_active_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_frames_left != '0))
        else $error("active flag disagrees with frame count");

    // The start segment only exists inside a transmission
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_start |-> r_active)
        else $error("start segment while idle");

    // The bit pointer stays inside the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos <= LAST_POS)
        else $error("bit position out of frame");

    // An accepted send from idle starts a transmission
    a_send_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_func && !r_active) |=> (r_active && r_in_start))
        else $error("send item did not start transmission");

endmodule

`default_nettype wire
